@@ sv/picture_unit_registers_and_timing_assert.svh @@
// ----------------------------------------------------------------------------
// Picture unit assertion macros
// Shared concurrent assertion forms for the picture unit RTL.
// ----------------------------------------------------------------------------
`ifndef PICTURE_UNIT_REGISTERS_AND_TIMING_ASSERT_SVH
`define PICTURE_UNIT_REGISTERS_AND_TIMING_ASSERT_SVH

// same-cycle implication
`define PURT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PURT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/purt_pkg.sv @@
// ----------------------------------------------------------------------------
// Picture unit package
// Payload types, action codes, address map constants and store mapping.
// ----------------------------------------------------------------------------
package purt_pkg;

    localparam int DATA_W      = 8;
    localparam int ADDR_W      = 14;
    localparam int DOT_W       = 9;
    localparam int LINE_W      = 9;
    localparam int SUM_W       = 10;
    localparam int NT_IDX_W    = 11;
    localparam int PAL_IDX_W   = 5;

    localparam int NAMETABLE_BYTES_DEF = 2048;
    localparam int PATTERN_BYTES_DEF   = 8192;
    localparam int PALETTE_BYTES       = 32;
    localparam int DOTS_PER_LINE_DEF   = 341;
    localparam int LINES_PER_FRAME_DEF = 262;
    localparam int VBLANK_LINE_DEF     = 241;

    localparam logic [ADDR_W-1:0] ADDR_PAT_LAST = 14'h1fff;
    localparam logic [ADDR_W-1:0] ADDR_NT_LAST  = 14'h3eff;
    localparam logic [ADDR_W-1:0] ADDR_STEP_ONE = 14'd1;
    localparam logic [ADDR_W-1:0] ADDR_STEP_ROW = 14'd32;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_ADDR   = 3'd1,
        ACT_CTRL   = 3'd2,
        ACT_READ   = 3'd3,
        ACT_STATUS = 3'd4,
        ACT_LOAD   = 3'd5
    } action_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [DATA_W-1:0] data;
        logic [7:0]        dots;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              frame_done;
    } out_t;

    typedef struct packed {
        logic       start;
        logic [7:0] dots;
        logic       nmi_en;
        logic       vblank_clr;
    } tim_ctrl_t;

    typedef struct packed {
        logic busy;
        logic fin;
        logic frame_done;
        logic vblank;
    } tim_stat_t;

    function automatic logic [NT_IDX_W-1:0] nt_index(
        input logic [ADDR_W-1:0] addr,
        input logic              vertical
    );
        logic bank;
        begin
            bank = vertical ? addr[10] : addr[11];
            return {bank, addr[9:0]};
        end
    endfunction

    function automatic logic [PAL_IDX_W-1:0] pal_index(input logic [ADDR_W-1:0] addr);
        logic [PAL_IDX_W-1:0] idx;
        begin
            idx = addr[PAL_IDX_W-1:0];
            if (idx[4] && (idx[1:0] == 2'b00))
            begin
                idx[4] = 1'b0;
            end
            return idx;
        end
    endfunction

endpackage

@@ sv/picture_unit_registers_and_timing.sv @@
// ----------------------------------------------------------------------------
// Picture unit registers and timing
// Each action goes from idle through its work state (S_READ for a data read, S_TICK for a
// tick) to S_DONE, which loads the output register; a stalled output holds it in S_DONE.
// One action at a time: the next is accepted only after S_DONE hands on the result; store reads are registered.
// A tick crosses N scanlines, one per cycle in the timing unit.
// Async active-low reset clears registers; stores are undefined until loaded.
// ----------------------------------------------------------------------------
`include "picture_unit_registers_and_timing_assert.svh"

module picture_unit_registers_and_timing
    import purt_pkg::*;
#(
    parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
    parameter int PATTERN_BYTES   = PATTERN_BYTES_DEF,
    parameter int DOTS_PER_LINE   = DOTS_PER_LINE_DEF,
    parameter int LINES_PER_FRAME = LINES_PER_FRAME_DEF,
    parameter int VBLANK_LINE     = VBLANK_LINE_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);

    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
    localparam int PAT_AW = $clog2(PATTERN_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_TICK,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              write_high_reg;
    logic              inc32_reg;
    logic              nmi_reg;
    logic              mirror_reg;
    logic [DATA_W-1:0] buf_reg;
    logic              pal_sel_reg;
    logic              pat_sel_reg;
    out_t              pend_reg;
    logic              out_valid_reg;
    out_t              out_data_reg;

    logic              accept;
    logic              load_out;
    logic              is_pat;
    logic              is_pal;
    logic              is_nt;
    logic              mem_rd;
    logic              mem_wr;
    logic [ADDR_W-1:0] pat_off;
    logic [PAT_AW-1:0] pat_idx;
    logic [NT_AW-1:0]  nt_idx;
    logic [DATA_W-1:0] pat_rdata;
    logic [DATA_W-1:0] nt_rdata;
    logic [DATA_W-1:0] pal_rdata;
    logic [ADDR_W-1:0] addr_step;
    tim_ctrl_t         tim_ctrl;
    tim_stat_t         tim_stat;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign is_pat = (addr_reg <= ADDR_PAT_LAST);
    assign is_pal = (addr_reg > ADDR_NT_LAST);
    assign is_nt  = !is_pat && !is_pal;
    assign mem_rd = accept && (in_data.action == ACT_READ);
    assign mem_wr = accept && (in_data.action == ACT_LOAD);

    assign pat_off   = {1'b0, addr_reg[ADDR_W-2:0]};
    assign pat_idx   = (pat_off >= ADDR_W'(PATTERN_BYTES))
                     ? PAT_AW'(pat_off - ADDR_W'(PATTERN_BYTES))
                     : PAT_AW'(pat_off);
    assign nt_idx    = NT_AW'(nt_index(addr_reg, mirror_reg));
    assign addr_step = inc32_reg ? ADDR_STEP_ROW : ADDR_STEP_ONE;

    purt_ram #(
        .DEPTH (PATTERN_BYTES)
    ) u_pat_ram (
        .clk   (clk),
        .addr  (pat_idx),
        .we    (mem_wr && is_pat),
        .wdata (in_data.data),
        .re    (mem_rd && is_pat),
        .rdata (pat_rdata)
    );

    purt_ram #(
        .DEPTH (NAMETABLE_BYTES)
    ) u_nt_ram (
        .clk   (clk),
        .addr  (nt_idx),
        .we    (mem_wr && is_nt),
        .wdata (in_data.data),
        .re    (mem_rd && is_nt),
        .rdata (nt_rdata)
    );

    purt_ram #(
        .DEPTH (PALETTE_BYTES)
    ) u_pal_ram (
        .clk   (clk),
        .addr  (pal_index(addr_reg)),
        .we    (mem_wr && is_pal),
        .wdata (in_data.data),
        .re    (mem_rd && is_pal),
        .rdata (pal_rdata)
    );

    assign tim_ctrl.start      = accept && (in_data.action == ACT_TICK);
    assign tim_ctrl.dots       = in_data.dots;
    assign tim_ctrl.nmi_en     = nmi_reg;
    assign tim_ctrl.vblank_clr = accept && (in_data.action == ACT_STATUS);

    purt_timing #(
        .DOTS_PER_LINE   (DOTS_PER_LINE),
        .LINES_PER_FRAME (LINES_PER_FRAME),
        .VBLANK_LINE     (VBLANK_LINE)
    ) u_timing (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tim_ctrl),
        .stat  (tim_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            addr_reg       <= '0;
            write_high_reg <= 1'b1;
            inc32_reg      <= 1'b0;
            nmi_reg        <= 1'b0;
            mirror_reg     <= 1'b0;
            buf_reg        <= '0;
            pal_sel_reg    <= 1'b0;
            pat_sel_reg    <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mirror_reg <= cfg_data;
            end
            if (load_out)
            begin
                out_data_reg  <= pend_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (in_data.action)
                            ACT_TICK:
                            begin
                                pend_reg  <= '0;
                                state_reg <= S_TICK;
                            end
                            ACT_ADDR:
                            begin
                                if (write_high_reg)
                                begin
                                    addr_reg <= {in_data.data[5:0], addr_reg[7:0]};
                                end
                                else
                                begin
                                    addr_reg <= {addr_reg[13:8], in_data.data};
                                end
                                write_high_reg <= !write_high_reg;
                                pend_reg       <= '0;
                                state_reg      <= S_DONE;
                            end
                            ACT_CTRL:
                            begin
                                inc32_reg <= in_data.data[2];
                                nmi_reg   <= in_data.data[7];
                                pend_reg  <= '0;
                                state_reg <= S_DONE;
                            end
                            ACT_READ:
                            begin
                                pal_sel_reg <= is_pal;
                                pat_sel_reg <= is_pat;
                                addr_reg    <= addr_reg + addr_step;
                                pend_reg    <= '0;
                                state_reg   <= S_READ;
                            end
                            ACT_STATUS:
                            begin
                                pend_reg       <= '{read_value: {tim_stat.vblank, 7'b0},
                                                    frame_done: 1'b0};
                                write_high_reg <= 1'b1;
                                state_reg      <= S_DONE;
                            end
                            ACT_LOAD:
                            begin
                                addr_reg  <= addr_reg + addr_step;
                                pend_reg  <= '0;
                                state_reg <= S_DONE;
                            end
                            default:
                            begin
                                pend_reg  <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    if (pal_sel_reg)
                    begin
                        pend_reg.read_value <= pal_rdata;
                    end
                    else
                    begin
                        pend_reg.read_value <= buf_reg;
                        buf_reg             <= pat_sel_reg ? pat_rdata : nt_rdata;
                    end
                    state_reg <= S_DONE;
                end
                S_TICK:
                begin
                    if (tim_stat.fin)
                    begin
                        pend_reg.frame_done <= tim_stat.frame_done;
                        state_reg           <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PURT_ASSERT_NEXT(a_one_item, clk, rst_n, accept, !in_ready, "item accepted while busy")
    `PURT_ASSERT_IMP(a_tick_busy, clk, rst_n, tim_stat.busy, state_reg == S_TICK, "timing busy outside tick")
    `PURT_ASSERT_NEXT(a_read_path, clk, rst_n, mem_rd, state_reg == S_READ, "data read skipped store")
    `PURT_ASSERT_NEXT(a_status_latch, clk, rst_n, accept && (in_data.action == ACT_STATUS), write_high_reg && !tim_stat.vblank, "status read did not reset latch")

endmodule

@@ sv/purt_ram.sv @@
// ----------------------------------------------------------------------------
// Picture unit store
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module purt_ram
    import purt_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic [AW-1:0]     addr,
    input  logic              we,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/purt_timing.sv @@
// ----------------------------------------------------------------------------
// Picture unit frame timing
// Dot and scanline counters; a tick retires one scanline per cycle.
// ----------------------------------------------------------------------------
module purt_timing
    import purt_pkg::*;
#(
    parameter int DOTS_PER_LINE   = DOTS_PER_LINE_DEF,
    parameter int LINES_PER_FRAME = LINES_PER_FRAME_DEF,
    parameter int VBLANK_LINE     = VBLANK_LINE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  tim_ctrl_t ctrl,
    output tim_stat_t stat
);

    localparam logic [SUM_W-1:0]  DPL = SUM_W'(DOTS_PER_LINE);
    localparam logic [LINE_W-1:0] LPF = LINE_W'(LINES_PER_FRAME);
    localparam logic [LINE_W-1:0] VBL = LINE_W'(VBLANK_LINE);

    logic [DOT_W-1:0]  dot_reg;
    logic [LINE_W-1:0] line_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              vblank_reg;
    logic [LINE_W-1:0] line_next;
    logic              step;

    assign step      = busy_reg && (sum_reg >= DPL);
    assign line_next = line_reg + LINE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg    <= '0;
            line_reg   <= '0;
            sum_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            vblank_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.vblank_clr)
            begin
                vblank_reg <= 1'b0;
            end
            if (ctrl.start)
            begin
                sum_reg  <= SUM_W'(dot_reg) + SUM_W'(ctrl.dots);
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            else if (step)
            begin
                sum_reg <= sum_reg - DPL;
                if (line_next >= LPF)
                begin
                    line_reg   <= '0;
                    vblank_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    line_reg <= line_next;
                    if ((line_next == VBL) && ctrl.nmi_en)
                    begin
                        vblank_reg <= 1'b1;
                    end
                end
            end
            else if (busy_reg)
            begin
                dot_reg  <= sum_reg[DOT_W-1:0];
                busy_reg <= 1'b0;
            end
        end
    end

    assign stat.busy       = busy_reg;
    assign stat.fin        = busy_reg && !step;
    assign stat.frame_done = done_reg;
    assign stat.vblank     = vblank_reg;

endmodule

@@ dv/picture_unit_registers_and_timing_tb.sv @@
// ----------------------------------------------------------------------------
// Picture unit registers and timing testbench
// Drives register, data and tick actions through the valid/ready input channel
// and checks every read value and frame-done flag against the directed table's
// expected values or a cycle-free model of the address latch, read buffer, stores and
// scanline counter. A directed table comes first, then random address/load/read blocks,
// tick runs and noise under each nametable mirroring mode, with random sender gaps,
// receiver stalls and one long receiver hold.
// ----------------------------------------------------------------------------
module picture_unit_registers_and_timing_tb;
    import purt_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO  = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI  = 3'd7;
    localparam logic [7:0] CTRL_ROW_STEP = 8'h04;
    localparam logic [7:0] CTRL_VBL_EN   = 8'h80;
    localparam logic [7:0] STAT_VBLANK   = 8'h80;
    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 435;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data;
        logic [7:0] dots;
        logic       typed;
        logic [7:0] read_value;
        logic       frame_done;
    } vector_t;

    localparam vector_t DIRECTED [0:24] = '{
        '{ACT_STATUS,   8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_TICK,     8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_TICK,     8'hff, 8'hff, 1'b1, 8'h00, 1'b0},
        '{ACT_CTRL,     8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_ADDR,     8'hff, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_ADDR,     8'h10, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_LOAD,     8'h5a, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_STATUS,   8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_ADDR,     8'h3f, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_ADDR,     8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_READ,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ACT_CTRL,     8'h84, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_ADDR,     8'h20, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_ADDR,     8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_LOAD,     8'hff, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_LOAD,     8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_ADDR,     8'hc0, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_ADDR,     8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_LOAD,     8'h81, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_ADDR,     8'h20, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_ADDR,     8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_READ,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ACT_READ,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ACT_SPARE_LO, 8'hff, 8'hff, 1'b1, 8'h00, 1'b0},
        '{ACT_SPARE_HI, 8'hff, 8'hff, 1'b1, 8'h00, 1'b0}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    in_t  in_data   = '0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_data  = 1'b0;
    logic cfg_ready;

    logic              mirror_vertical = 1'b0;
    logic [ADDR_W-1:0] vram_addr       = '0;
    logic              high_byte_next  = 1'b1;
    logic [7:0]        ctrl_reg        = '0;
    logic [7:0]        status_reg      = '0;
    logic [7:0]        read_buf        = '0;
    int                dot_acc         = 0;
    int                line_no         = 0;

    logic [7:0] pattern_mem   [PATTERN_BYTES_DEF];
    logic [7:0] nametable_mem [NAMETABLE_BYTES_DEF];
    logic [7:0] palette_mem   [PALETTE_BYTES];
    bit         pattern_set   [PATTERN_BYTES_DEF];
    bit         nametable_set [NAMETABLE_BYTES_DEF];
    bit         palette_set   [PALETTE_BYTES];

    out_t bus_response_q [$];
    int   error_count  = 0;
    int   actions_sent = 0;
    int   burst_left   = 4;
    bit   no_gaps      = 1'b0;
    bit   hold_request = 1'b0;

    picture_unit_registers_and_timing uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic in_t make_item(input logic [2:0] action, input logic [7:0] data,
                                      input logic [7:0] dots);
        in_t item;
        item.action = action;
        item.data   = data;
        item.dots   = dots;
        return item;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [NT_IDX_W-1:0] nametable_slot(input logic [ADDR_W-1:0] addr);
        logic bank;
        bank = mirror_vertical ? addr[10] : addr[11];
        return {bank, addr[9:0]};
    endfunction

    function automatic logic [PAL_IDX_W-1:0] palette_slot(input logic [ADDR_W-1:0] addr);
        logic [PAL_IDX_W-1:0] slot;
        slot = addr[PAL_IDX_W-1:0];
        if ((slot & 5'h13) == 5'h10)
        begin
            slot = slot - 5'h10;
        end
        return slot;
    endfunction

    function automatic bit store_entry_known();
        if (vram_addr <= ADDR_PAT_LAST)
        begin
            return pattern_set[vram_addr[12:0]];
        end
        else if (vram_addr <= ADDR_NT_LAST)
        begin
            return nametable_set[nametable_slot(vram_addr)];
        end
        return palette_set[palette_slot(vram_addr)];
    endfunction

    task automatic step_picture_unit(input in_t item, output out_t res);
        res = '0;
        case (item.action)
            ACT_TICK:
            begin
                dot_acc += item.dots;
                while (dot_acc >= DOTS_PER_LINE_DEF)
                begin
                    dot_acc -= DOTS_PER_LINE_DEF;
                    line_no++;
                    if (line_no == VBLANK_LINE_DEF && (ctrl_reg & CTRL_VBL_EN) != 8'h00)
                    begin
                        status_reg = status_reg | STAT_VBLANK;
                    end
                    if (line_no >= LINES_PER_FRAME_DEF)
                    begin
                        line_no        = 0;
                        status_reg     = status_reg & ~STAT_VBLANK;
                        res.frame_done = 1'b1;
                    end
                end
            end
            ACT_ADDR:
            begin
                if (high_byte_next)
                begin
                    vram_addr = {item.data[5:0], vram_addr[7:0]};
                end
                else
                begin
                    vram_addr = {vram_addr[13:8], item.data};
                end
                high_byte_next = ~high_byte_next;
            end
            ACT_CTRL:
            begin
                ctrl_reg = item.data;
            end
            ACT_READ:
            begin
                if (vram_addr <= ADDR_PAT_LAST)
                begin
                    res.read_value = read_buf;
                    read_buf       = pattern_mem[vram_addr[12:0]];
                end
                else if (vram_addr <= ADDR_NT_LAST)
                begin
                    res.read_value = read_buf;
                    read_buf       = nametable_mem[nametable_slot(vram_addr)];
                end
                else
                begin
                    res.read_value = palette_mem[palette_slot(vram_addr)];
                end
                vram_addr += ((ctrl_reg & CTRL_ROW_STEP) != 8'h00) ? ADDR_STEP_ROW : ADDR_STEP_ONE;
            end
            ACT_STATUS:
            begin
                res.read_value = status_reg;
                status_reg     = status_reg & ~STAT_VBLANK;
                high_byte_next = 1'b1;
            end
            ACT_LOAD:
            begin
                if (vram_addr <= ADDR_PAT_LAST)
                begin
                    pattern_mem[vram_addr[12:0]] = item.data;
                    pattern_set[vram_addr[12:0]] = 1'b1;
                end
                else if (vram_addr <= ADDR_NT_LAST)
                begin
                    nametable_mem[nametable_slot(vram_addr)] = item.data;
                    nametable_set[nametable_slot(vram_addr)] = 1'b1;
                end
                else
                begin
                    palette_mem[palette_slot(vram_addr)] = item.data;
                    palette_set[palette_slot(vram_addr)] = 1'b1;
                end
                vram_addr += ((ctrl_reg & CTRL_ROW_STEP) != 8'h00) ? ADDR_STEP_ROW : ADDR_STEP_ONE;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_item(input in_t item, input logic typed, input out_t typed_res);
        out_t res;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        step_picture_unit(item, res);
        bus_response_q = {bus_response_q, (typed ? typed_res : res)};
        if (item.action <= ACT_LOAD)
        begin
            actions_sent++;
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0 && !no_gaps)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // turn a read of a never-written entry into a load of that entry
    task automatic issue(input in_t item);
        if (item.action == ACT_READ && !store_entry_known())
        begin
            item.action = ACT_LOAD;
        end
        send_item(item, 1'b0, '0);
    endtask

    task automatic point_at(input logic [ADDR_W-1:0] addr);
        issue(make_item(ACT_STATUS, rand_byte(), rand_byte()));
        issue(make_item(ACT_ADDR, {2'($urandom_range(0, 3)), addr[13:8]}, rand_byte()));
        issue(make_item(ACT_ADDR, addr[7:0], rand_byte()));
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        case ($urandom_range(0, 5))
            0: return 14'($urandom_range(16'h0000, 16'h1fff));
            1: return 14'($urandom_range(16'h2000, 16'h3eff));
            2: return 14'($urandom_range(16'h3f00, 16'h3fff));
            3: return 14'($urandom_range(16'h3ef0, 16'h3f10));
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return 14'h0000;
                    1: return 14'h1ff8;
                    2: return 14'h3ef8;
                    default: return 14'h3ff8;
                endcase
            end
            default: return 14'($urandom);
        endcase
    endfunction

    task automatic run_random(input int count);
        int stop_at;
        int len;
        int pick;
        logic [ADDR_W-1:0] base;
        stop_at = actions_sent + count;
        while (actions_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    issue(make_item(ACT_CTRL, rand_byte(), rand_byte()));
                end
                base = pick_address();
                len  = $urandom_range(1, 8);
                point_at(base);
                repeat (len) issue(make_item(ACT_LOAD, rand_byte(), rand_byte()));
                point_at(base);
                repeat (len + $urandom_range(0, 1))
                    issue(make_item(ACT_READ, rand_byte(), rand_byte()));
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    issue(make_item(ACT_CTRL, rand_byte() | CTRL_VBL_EN, rand_byte()));
                end
                repeat ($urandom_range(10, 60))
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        issue(make_item(ACT_STATUS, rand_byte(), rand_byte()));
                    end
                    else
                    begin
                        issue(make_item(ACT_TICK, rand_byte(),
                                        ($urandom_range(0, 3) == 0) ? rand_byte()
                                                                    : 8'($urandom_range(220, 255))));
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                    issue(make_item(3'($urandom_range(0, 7)), rand_byte(), rand_byte()));
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (bus_response_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_mirroring(input logic vertical);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= vertical;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid       <= 1'b0;
        mirror_vertical  = vertical;
    endtask

    initial
    begin
        in_t  item;
        out_t typed_res;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mirroring(1'b0);
        for (int i = 0; i < 25; i++)
        begin
            item = make_item(DIRECTED[i].action, DIRECTED[i].data, DIRECTED[i].dots);
            typed_res.read_value = DIRECTED[i].read_value;
            typed_res.frame_done = DIRECTED[i].frame_done;
            send_item(item, DIRECTED[i].typed, typed_res);
        end
        set_mirroring(1'b1);
        run_random(PHASE_ITEMS);
        set_mirroring(1'b0);
        hold_request = 1'b1;
        run_random(PHASE_ITEMS);
        set_mirroring(1'b1);
        no_gaps = 1'b1;
        run_random(PHASE_ITEMS / 3);
        no_gaps = 1'b0;
        run_random(PHASE_ITEMS - PHASE_ITEMS / 3);
        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  hold_taken;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= (mode_left % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (bus_response_q.size() == 0)
            begin
                $error("unrequested transfer: read_value %0h frame_done %0b",
                       out_data.read_value, out_data.frame_done);
                error_count++;
            end
            else
            begin
                want = bus_response_q.pop_front();
                if (out_data.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0h, actual %0h",
                           want.read_value, out_data.read_value);
                    error_count++;
                end
                if (out_data.frame_done !== want.frame_done)
                begin
                    $error("frame_done: expected %0b, actual %0b",
                           want.frame_done, out_data.frame_done);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
